### sv/lmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmp_pkg
// shared types and constants of the legendre multipole projector
// ----------------------------------------------------------------------------
package lmp_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned PADDR_W = 3;
	localparam logic [0:0] REG_MU_BIN_WIDTH = 1'b0;
	localparam logic [15:0] MU_BIN_WIDTH_RST = 16'd3277;
	localparam logic signed [15:0] MU_ONE = 16'sd16384;
	localparam logic signed [15:0] MU_NEG_ONE = -16'sd16384;
	localparam int unsigned ROOT_STEPS = 32;

	// one classified sample, front to back
	typedef struct packed {
		logic [31:0]        radius;
		logic signed [31:0] xi;
		logic [31:0]        err;
		logic signed [31:0] p2;
		logic signed [31:0] p4;
		logic               last;
	} lmp_item_t;

	// back status seen by the top level
	typedef struct packed {
		logic issue_last;
		logic pend;
	} lmp_stat_t;

endpackage
`default_nettype wire

### sv/lmp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmp_front
// input stage: clamps mu and forms the P2 and P4 polynomials
// ----------------------------------------------------------------------------
module lmp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [31:0]       radius,
	input  wire logic signed [15:0] mu_value,
	input  wire logic signed [31:0] xi_value,
	input  wire logic [31:0]       xi_error,
	input  wire logic              last_in_row,
	output logic                   q_push,
	output lmp_pkg::lmp_item_t     q_item,
	input  wire logic              q_full
);
	import lmp_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;
	logic [31:0] radius_s1, radius_s2, radius_s3;
	logic signed [31:0] xi_s1, xi_s2, xi_s3;
	logic [31:0] err_s1, err_s2, err_s3;
	logic last_s1, last_s2, last_s3;
	logic signed [15:0] m_s1;
	logic signed [15:0] m_c;
	logic signed [31:0] msq_c;
	logic [28:0] m2_s2, m2_s3;
	logic [57:0] m4_c;
	logic [56:0] m4_s3;
	logic signed [31:0] p2_c, p2_s3;
	logic [63:0] p4_u;
	logic signed [63:0] p4_sh;
	lmp_item_t item_s4;

	assign adv = !v_s4 || !q_full;
	assign in_stall = !adv;
	assign q_push = v_s4 && !q_full;
	assign q_item = item_s4;

	always_comb begin
		priority if (mu_value > MU_ONE) begin
			m_c = MU_ONE;
		end else if (mu_value < MU_NEG_ONE) begin
			m_c = MU_NEG_ONE;
		end else begin
			m_c = mu_value;
		end
	end

	assign msq_c = 32'(m_s1) * 32'(m_s1);
	assign m4_c = {29'b0, m2_s2} * {29'b0, m2_s2};
	assign p2_c = $signed(({3'b0, m2_s2} * 32'd6) - 32'h2000_0000);
	// p4 = rnd((35 m4 - 30 2^28 m2 + 3 2^56) / 2^29)
	assign p4_u = (64'(m4_s3) * 64'd35) + (64'd3 << 56) + (64'd1 << 28)
		- ((64'(m2_s3) * 64'd30) << 28);
	assign p4_sh = $signed(p4_u) >>> 29;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			radius_s1 <= radius;
			xi_s1     <= xi_value;
			err_s1    <= xi_error;
			last_s1   <= last_in_row;
			m_s1      <= m_c;
			radius_s2 <= radius_s1;
			xi_s2     <= xi_s1;
			err_s2    <= err_s1;
			last_s2   <= last_s1;
			m2_s2     <= msq_c[28:0];
			radius_s3 <= radius_s2;
			xi_s3     <= xi_s2;
			err_s3    <= err_s2;
			last_s3   <= last_s2;
			m2_s3     <= m2_s2;
			m4_s3     <= m4_c[56:0];
			p2_s3     <= p2_c;
			item_s4.radius <= radius_s3;
			item_s4.xi     <= xi_s3;
			item_s4.err    <= err_s3;
			item_s4.last   <= last_s3;
			item_s4.p2     <= p2_s3;
			item_s4.p4     <= p4_sh[31:0];
		end
	end

endmodule
`default_nettype wire

### sv/lmp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmp_queue
// short queue of classified samples between front and back
// ----------------------------------------------------------------------------
module lmp_queue #(
	parameter int unsigned DEPTH = lmp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  lmp_pkg::lmp_item_t item_in,
	output logic               full,
	input  wire logic          pop,
	output lmp_pkg::lmp_item_t item_out,
	output logic               empty
);
	import lmp_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	lmp_item_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] cnt_q;

	assign full = (cnt_q == (PW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign item_out = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item_in;
		end
	end

endmodule
`default_nettype wire

### sv/lmp_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmp_isqrt
// floor square root of a 64 bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module lmp_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] n,
	output logic             busy,
	output logic             done,
	output logic [31:0]      root
);
	import lmp_pkg::*;

	logic [63:0] rem_q, res_q;
	logic [4:0] step_q;
	logic busy_q, done_q;
	logic [63:0] bit_c, trial_c;
	logic [5:0] shift_c;

	assign shift_c = 6'd62 - {step_q, 1'b0};
	assign bit_c = 64'd1 << shift_c;
	assign trial_c = res_q + bit_c;
	assign busy = busy_q;
	assign done = done_q;
	assign root = res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 5'(ROOT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= n;
			res_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= trial_c) begin
				rem_q <= rem_q - trial_c;
				res_q <= (res_q >> 1) + bit_c;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

endmodule
`default_nettype wire

### sv/lmp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmp_back
// term pipeline, saturating sums, roots and result register
// ----------------------------------------------------------------------------
module lmp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [15:0]       mu_bin_width,
	input  wire logic              q_empty,
	input  lmp_pkg::lmp_item_t     q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [31:0]            radius_res,
	output logic signed [47:0]     monopole,
	output logic signed [47:0]     quadrupole,
	output logic signed [47:0]     hexadecapole,
	output logic [47:0]            monopole_error,
	output logic [47:0]            quadrupole_error,
	output logic [47:0]            hexadecapole_error,
	output lmp_pkg::lmp_stat_t     stat
);
	import lmp_pkg::*;

	typedef enum logic [1:0] {TERM_L0, TERM_L2, TERM_L4} term_t;

	function automatic logic signed [63:0] add_sat_s(logic signed [63:0] a,
		logic signed [40:0] b);
		logic signed [63:0] bx;
		logic signed [63:0] s;
		bx = 64'(b);
		s = a + bx;
		if (a[63] == bx[63] && s[63] != a[63]) begin
			s = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		end
		return s;
	endfunction

	function automatic logic [63:0] add_sat_u(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic signed [47:0] sat48(logic signed [63:0] v);
		logic signed [47:0] r;
		if (v[63:47] == '0 || v[63:47] == '1) begin
			r = v[47:0];
		end else begin
			r = v[63] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		end
		return r;
	endfunction

	term_t cnt_q;
	logic pend_q, rdone_q, out_valid_q;
	logic can_issue, fin_c, load;
	logic signed [31:0] p_c;
	logic [19:0] cw_c;
	logic signed [32:0] err_c;

	// pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic fin_s1, fin_s2, fin_s3, fin_s4, fin_s5;
	term_t l_s1, l_s2, l_s3, l_s4, l_s5;
	logic [31:0] rad_s1, rad_s2, rad_s3, rad_s4, rad_s5;
	logic signed [63:0] pv_s1, pe_s1;
	logic [19:0] cw_s1, cw_s2;
	logic signed [63:0] rv_c, re_c;
	logic signed [35:0] tv_s2, te_s2;
	logic signed [56:0] xv_s3, xe_s3;
	logic signed [56:0] yv_c, ye_c;
	logic signed [40:0] ev_s4, ee_s4;
	logic [40:0] mag_c;
	logic signed [40:0] tv_s5;
	logic [63:0] sq_s5;

	// sums
	logic signed [63:0] sum_q [3];
	logic [63:0] sqs_q [3];
	logic signed [63:0] sum_new;
	logic [63:0] sqs_new;

	// row snapshot and roots
	logic [31:0] snap_rad_q;
	logic signed [47:0] snap_mono_q, snap_quad_q, snap_hexa_q;
	logic [63:0] root_n [3];
	logic [31:0] root_r [3];
	logic [2:0] root_busy, root_done;

	// ---------------- issue ----------------
	assign can_issue = !q_empty && !(q_item.last && pend_q && cnt_q == TERM_L0);
	assign q_pop = can_issue && cnt_q == TERM_L4;
	assign fin_c = q_pop && q_item.last;
	assign err_c = $signed({1'b0, q_item.err});
	assign stat.issue_last = fin_c;
	assign stat.pend = pend_q;

	always_comb begin
		unique case (cnt_q)
			TERM_L0: begin
				p_c = 32'sh4000_0000;
				cw_c = {4'b0, mu_bin_width};
			end
			TERM_L2: begin
				p_c = q_item.p2;
				cw_c = {4'b0, mu_bin_width} * 20'd5;
			end
			TERM_L4: begin
				p_c = q_item.p4;
				cw_c = {4'b0, mu_bin_width} * 20'd9;
			end
			default: begin
				p_c = '0;
				cw_c = '0;
			end
		endcase
	end

	// ---------------- datapath ----------------
	assign rv_c = (pv_s1 + 64'sd536870912) >>> 30;
	assign re_c = (pe_s1 + 64'sd536870912) >>> 30;
	assign yv_c = (xv_s3 + 57'sd32768) >>> 16;
	assign ye_c = (xe_s3 + 57'sd32768) >>> 16;
	assign mag_c = ee_s4[40] ? 41'(-ee_s4) : 41'(ee_s4);
	assign sum_new = add_sat_s(sum_q[l_s5], tv_s5);
	assign sqs_new = add_sat_u(sqs_q[l_s5], sq_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= TERM_L0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
				sqs_q[i] <= '0;
			end
		end else begin
			if (can_issue) begin
				cnt_q <= (cnt_q == TERM_L4) ? TERM_L0 : term_t'(cnt_q + 2'd1);
			end
			v_s1 <= can_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (v_s5) begin
				if (fin_s5) begin
					for (int i = 0; i < 3; i++) begin
						sum_q[i] <= '0;
						sqs_q[i] <= '0;
					end
				end else begin
					sum_q[l_s5] <= sum_new;
					sqs_q[l_s5] <= sqs_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		fin_s1 <= fin_c;
		l_s1   <= cnt_q;
		rad_s1 <= q_item.radius;
		pv_s1  <= 64'(q_item.xi) * 64'(p_c);
		pe_s1  <= 64'(err_c) * 64'(p_c);
		cw_s1  <= cw_c;
		fin_s2 <= fin_s1;
		l_s2   <= l_s1;
		rad_s2 <= rad_s1;
		tv_s2  <= rv_c[35:0];
		te_s2  <= re_c[35:0];
		cw_s2  <= cw_s1;
		fin_s3 <= fin_s2;
		l_s3   <= l_s2;
		rad_s3 <= rad_s2;
		xv_s3  <= 57'(tv_s2) * 57'($signed({1'b0, cw_s2}));
		xe_s3  <= 57'(te_s2) * 57'($signed({1'b0, cw_s2}));
		fin_s4 <= fin_s3;
		l_s4   <= l_s3;
		rad_s4 <= rad_s3;
		ev_s4  <= yv_c[40:0];
		ee_s4  <= ye_c[40:0];
		fin_s5 <= fin_s4;
		l_s5   <= l_s4;
		rad_s5 <= rad_s4;
		tv_s5  <= ev_s4;
		sq_s5  <= (mag_c[40:32] != '0) ? '1 : 64'(mag_c[31:0]) * 64'(mag_c[31:0]);
		if (v_s5 && fin_s5) begin
			snap_rad_q  <= rad_s5;
			snap_mono_q <= sat48(sum_q[0]);
			snap_quad_q <= sat48(sum_q[1]);
			snap_hexa_q <= sat48(sum_new);
		end
	end

	// ---------------- roots ----------------
	assign root_n[0] = sqs_q[0];
	assign root_n[1] = sqs_q[1];
	assign root_n[2] = sqs_new;

	for (genvar g = 0; g < 3; g++) begin : g_root
		lmp_isqrt u_isqrt (
			.clk   (clk),
			.arst_n(arst_n),
			.start (v_s5 && fin_s5),
			.n     (root_n[g]),
			.busy  (root_busy[g]),
			.done  (root_done[g]),
			.root  (root_r[g])
		);
	end

	// ---------------- result register ----------------
	assign load = rdone_q && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			rdone_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_c) begin
				pend_q <= 1'b1;
			end else if (load) begin
				pend_q <= 1'b0;
			end
			if ((&root_done) && !(|root_busy)) begin
				rdone_q <= 1'b1;
			end else if (load) begin
				rdone_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			radius_res         <= snap_rad_q;
			monopole           <= snap_mono_q;
			quadrupole         <= snap_quad_q;
			hexadecapole       <= snap_hexa_q;
			monopole_error     <= {16'b0, root_r[0]};
			quadrupole_error   <= {16'b0, root_r[1]};
			hexadecapole_error <= {16'b0, root_r[2]};
		end
	end

endmodule
`default_nettype wire

### sv/legendre_multipole_projector_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// after its last sample is accepted, a row's result passes through
// 4 front stages, queue write, term issue, 5 term stages, 32 root steps and the result register
// the term multipliers take one legendre order per cycle, as long as the queue holds a sample
// a following row end waits until the previous row's roots have left for the result register
// reset: asynchronous, clears sums, queue, flags; mu_bin_width returns to 3277
// ----------------------------------------------------------------------------
// legendre_multipole_projector_unit
// projects radial rows of a (r, mu) correlation grid onto l = 0, 2, 4
// ----------------------------------------------------------------------------
module legendre_multipole_projector_unit #(
	parameter int unsigned QUEUE_DEPTH = lmp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// apb configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lmp_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// sample input
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [31:0]                   radius,
	input  wire logic signed [15:0]            mu_value,
	input  wire logic signed [31:0]            xi_value,
	input  wire logic [31:0]                   xi_error,
	input  wire logic                          last_in_row,
	// row result
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [31:0]                        radius_res,
	output logic signed [47:0]                 monopole,
	output logic signed [47:0]                 quadrupole,
	output logic signed [47:0]                 hexadecapole,
	output logic [47:0]                        monopole_error,
	output logic [47:0]                        quadrupole_error,
	output logic [47:0]                        hexadecapole_error
);
	import lmp_pkg::*;

	logic [15:0] mu_bin_width_q;
	logic reg_sel;
	logic q_push, q_full, q_pop, q_empty;
	lmp_item_t q_in, q_out;
	lmp_stat_t stat;

	// register file: one register, word index taken above the byte offset
	assign pready = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1] == REG_MU_BIN_WIDTH);
	assign prdata = reg_sel ? {16'b0, mu_bin_width_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_bin_width_q <= MU_BIN_WIDTH_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			mu_bin_width_q <= pwdata[15:0];
		end
	end

	// front: clamp and polynomial evaluation
	lmp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.radius     (radius),
		.mu_value   (mu_value),
		.xi_value   (xi_value),
		.xi_error   (xi_error),
		.last_in_row(last_in_row),
		.q_push     (q_push),
		.q_item     (q_in),
		.q_full     (q_full)
	);

	// decoupling queue, lets the back absorb the per-row root time
	lmp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.item_in (q_in),
		.full    (q_full),
		.pop     (q_pop),
		.item_out(q_out),
		.empty   (q_empty)
	);

	// back: weighted terms, saturating sums, square roots, result transfer
	lmp_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.mu_bin_width      (mu_bin_width_q),
		.q_empty           (q_empty),
		.q_item            (q_out),
		.q_pop             (q_pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.radius_res        (radius_res),
		.monopole          (monopole),
		.quadrupole        (quadrupole),
		.hexadecapole      (hexadecapole),
		.monopole_error    (monopole_error),
		.quadrupole_error  (quadrupole_error),
		.hexadecapole_error(hexadecapole_error),
		.stat              (stat)
	);

	// queue never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue overflow");

	// a row end is only issued when no row result is outstanding
	a_one_row: assert property (@(posedge clk) disable iff (!arst_n)
		stat.issue_last |-> !stat.pend) else $error("row end issued while pending");

	// a new result only comes from an outstanding row
	a_out_from_row: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(stat.pend)) else $error("result without row");

endmodule
`default_nettype wire

### bench/lmp_row_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmp_row_checker
// watches the sample and row channels, predicts each row result, compares
// ----------------------------------------------------------------------------
module lmp_row_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic                        pready,
	input  wire logic [lmp_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	input  wire logic                        in_valid,
	input  wire logic                        in_stall,
	input  wire logic [31:0]                 radius,
	input  wire logic signed [15:0]          mu_value,
	input  wire logic signed [31:0]          xi_value,
	input  wire logic [31:0]                 xi_error,
	input  wire logic                        last_in_row,
	input  wire logic                        out_valid,
	input  wire logic                        out_stall,
	input  wire logic [31:0]                 radius_res,
	input  wire logic signed [47:0]          monopole,
	input  wire logic signed [47:0]          quadrupole,
	input  wire logic signed [47:0]          hexadecapole,
	input  wire logic [47:0]                 monopole_error,
	input  wire logic [47:0]                 quadrupole_error,
	input  wire logic [47:0]                 hexadecapole_error,
	output int                               fail_count,
	output int                               rows_pending
);
	import lmp_pkg::*;

	typedef struct {
		logic [31:0]        radius;
		logic signed [47:0] pole [3];
		logic [47:0]        pole_err [3];
	} row_result_t;

	row_result_t rows_due [$];
	logic [15:0] bin_width;
	longint      pole_sum [3];
	longint unsigned err_sq_sum [3];

	function automatic longint rnd_shift(longint x, int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint weighted_term(longint v, longint p, longint c, longint w);
		return rnd_shift(rnd_shift(v * p, 30) * c * w, 16);
	endfunction

	function automatic longint sat_add_s(longint a, longint b);
		logic signed [64:0] t;
		t = a + b;
		if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF)
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (t < -65'sh0_8000_0000_0000_0000)
			return 64'sh8000_0000_0000_0000;
		return t[63:0];
	endfunction

	function automatic longint unsigned sat_add_u(longint unsigned a, longint unsigned b);
		logic [64:0] t;
		t = a + b;
		return t[64] ? '1 : t[63:0];
	endfunction

	function automatic longint unsigned sat_square(longint e);
		longint unsigned mag;
		mag = (e < 0) ? -e : e;
		if (mag >= 64'h1_0000_0000)
			return '1;
		return mag * mag;
	endfunction

	function automatic logic [47:0] floor_root(longint unsigned n);
		longint unsigned acc, bitv;
		acc  = 0;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= acc + bitv) begin
				n   = n - (acc + bitv);
				acc = (acc >> 1) + bitv;
			end else begin
				acc = acc >> 1;
			end
			bitv = bitv >> 2;
		end
		return acc[47:0];
	endfunction

	function automatic logic signed [47:0] clip48(longint v);
		if (v > 64'sh0000_7FFF_FFFF_FFFF)
			return 48'sh7FFF_FFFF_FFFF;
		if (v < -64'sh0000_8000_0000_0000)
			return 48'sh8000_0000_0000;
		return v[47:0];
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic accumulate_sample();
		longint m, m2, m4, w, xi, er;
		longint poly [3];
		longint coef [3];
		row_result_t r;
		m = mu_value;
		if (m > MU_ONE)
			m = MU_ONE;
		if (m < MU_NEG_ONE)
			m = MU_NEG_ONE;
		m2 = m * m;
		m4 = m2 * m2;
		poly[0] = longint'(1) <<< 30;
		poly[1] = 6 * m2 - (longint'(1) <<< 29);
		poly[2] = rnd_shift(35 * m4 - 30 * (m2 <<< 28) + 3 * (longint'(1) <<< 56), 29);
		coef = '{1, 5, 9};
		w  = bin_width;
		xi = xi_value;
		er = xi_error;
		for (int k = 0; k < 3; k++) begin
			pole_sum[k]   = sat_add_s(pole_sum[k], weighted_term(xi, poly[k], coef[k], w));
			err_sq_sum[k] = sat_add_u(err_sq_sum[k],
				sat_square(weighted_term(er, poly[k], coef[k], w)));
		end
		if (last_in_row) begin
			r.radius = radius;
			for (int k = 0; k < 3; k++) begin
				r.pole[k]     = clip48(pole_sum[k]);
				r.pole_err[k] = floor_root(err_sq_sum[k]);
				pole_sum[k]   = 0;
				err_sq_sum[k] = 0;
			end
			rows_due.insert(rows_due.size(), r);
		end
	endtask

	task automatic compare_row();
		row_result_t r;
		if (rows_due.size() == 0) begin
			report_mismatch("unexpected row", radius_res, 0);
		end else begin
			r = rows_due.pop_front();
			if (radius_res !== r.radius)
				report_mismatch("radius_res", radius_res, r.radius);
			if (monopole !== r.pole[0])
				report_mismatch("monopole", monopole, r.pole[0]);
			if (quadrupole !== r.pole[1])
				report_mismatch("quadrupole", quadrupole, r.pole[1]);
			if (hexadecapole !== r.pole[2])
				report_mismatch("hexadecapole", hexadecapole, r.pole[2]);
			if (monopole_error !== r.pole_err[0])
				report_mismatch("monopole_error", monopole_error, r.pole_err[0]);
			if (quadrupole_error !== r.pole_err[1])
				report_mismatch("quadrupole_error", quadrupole_error, r.pole_err[1]);
			if (hexadecapole_error !== r.pole_err[2])
				report_mismatch("hexadecapole_error", hexadecapole_error, r.pole_err[2]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width  <= MU_BIN_WIDTH_RST;
			pole_sum   = '{0, 0, 0};
			err_sq_sum = '{0, 0, 0};
			rows_due.delete();
			rows_pending = 0;
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && (paddr >> 2) == REG_MU_BIN_WIDTH)
				bin_width <= pwdata[15:0];
			if (in_valid && !in_stall)
				accumulate_sample();
			if (out_valid && !out_stall)
				compare_row();
			rows_pending = rows_due.size();
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// streams rows of (mu, xi, error) samples through the projector under
// several bin widths, with random idling on both channels
// ----------------------------------------------------------------------------
module testbench;
	import lmp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	wire logic [31:0] prdata;
	wire logic pready;
	logic in_valid = 1'b0;
	wire logic in_stall;
	logic [31:0] radius = '0;
	logic signed [15:0] mu_value = '0;
	logic signed [31:0] xi_value = '0;
	logic [31:0] xi_error = '0;
	logic last_in_row = 1'b0;
	wire logic out_valid;
	logic out_stall = 1'b0;
	wire logic [31:0] radius_res;
	wire logic signed [47:0] monopole, quadrupole, hexadecapole;
	wire logic [47:0] monopole_error, quadrupole_error, hexadecapole_error;
	int fail_count, rows_pending;
	// no idling on either side in the closing part
	logic calm = 1'b0;
	int row_serial = 0;

	always #5 clk = ~clk;

	legendre_multipole_projector_unit i_dut (.*);

	lmp_row_checker i_checker (.*);

	// receiver stall in random bursts
	always @(posedge clk) begin
		int hold;
		if (calm) begin
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			hold = $urandom_range(1, 17);
			out_stall <= 1'b1;
			repeat (hold) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	task automatic apb_write(logic [15:0] w);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= PADDR_W'(4 * REG_MU_BIN_WIDTH);
		pwdata  <= {16'h0, w};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait for the block to drain, then the result pipeline latency
	task automatic drain_rows();
		while (rows_pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// one sample transfer, optional sender gap afterwards
	task automatic send_sample(logic [31:0] r, logic signed [15:0] mu,
			logic signed [31:0] xi, logic [31:0] er, logic last);
		int gap;
		in_valid    <= 1'b1;
		radius      <= r;
		mu_value    <= mu;
		xi_value    <= xi;
		xi_error    <= er;
		last_in_row <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic close_channel();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_mu();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? MU_ONE : MU_NEG_ONE;
			default: return 16'sd16384 - 16'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [31:0] pick_big_or_small();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0004_0000);
			2: return 32'($signed($urandom_range(0, 32'h0004_0000))) * -1;
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic random_rows(int samples);
		int len;
		logic [31:0] r;
		while (samples > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			r   = $urandom;
			for (int k = 0; k < len; k++)
				send_sample(r, pick_mu(), pick_big_or_small(), pick_big_or_small(),
					k == len - 1);
			samples -= len;
		end
	endtask

	initial begin
		logic [15:0] widths [4];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset width first, directed corners
		send_sample(32'h0001_0000, MU_ONE, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0001_0000, MU_NEG_ONE, -32'sh8000_0000, 32'h0, 1'b0);
		send_sample(32'h0001_0000, 16'sh7FFF, 32'sh0001_0000, 32'h0001_0000, 1'b0);
		send_sample(32'h0001_0000, -16'sh8000, -32'sh0001_0000, 32'h0000_8000, 1'b0);
		send_sample(32'hFFFF_FFFF, 16'sd0, 32'sh0, 32'h1234_5678, 1'b1);
		// single-sample rows
		send_sample(32'h0, 16'sd8192, 32'sh0000_4000, 32'h0, 1'b1);
		send_sample(32'hA5A5_5A5A, -16'sd9459, 32'shFFFF_0000, 32'hFFFF_FFFF, 1'b1);
		close_channel();
		drain_rows();

		// widest bin: error squares overflow into all ones
		apb_write(16'hFFFF);
		send_sample(32'h2, MU_ONE, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_sample(32'h2, MU_ONE, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_sample(32'h3, MU_NEG_ONE, -32'sh8000_0000, 32'hFFFF_FFFF, 1'b1);
		// a longer row of full-scale samples builds up large multipoles
		for (int k = 0; k < 40; k++)
			send_sample(32'h4, MU_ONE, 32'sh7FFF_FFFF, 32'h0000_0001, k == 39);
		close_channel();
		drain_rows();

		// zero width: everything collapses to zero
		apb_write(16'h0000);
		send_sample(32'h5, 16'sd1000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_sample(32'h5, MU_ONE, -32'sh8000_0000, 32'hFFFF_FFFF, 1'b1);
		random_rows(40);
		close_channel();
		drain_rows();

		widths = '{16'd1, 16'hFFFF, 16'($urandom), MU_BIN_WIDTH_RST};
		foreach (widths[i]) begin
			apb_write(widths[i]);
			random_rows(180);
			// sender holds off until the block has caught up
			close_channel();
			drain_rows();
		end

		calm = 1'b1;
		random_rows(40);
		close_channel();
		drain_rows();

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

### legendre_multipole_projector_unit.f
sv/lmp_pkg.sv
sv/lmp_front.sv
sv/lmp_queue.sv
sv/lmp_isqrt.sv
sv/lmp_back.sv
sv/legendre_multipole_projector_unit.sv
bench/lmp_row_checker.sv
bench/testbench.sv
